// ===== src/assert_macros.svh =====
// Assertion macros used by the RTL top level of the RSI block.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(label, a, c, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(label, a, c, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) \
        else $error(msg);

`endif

// ===== src/rsi_pkg.sv =====
// Package of the RSI block: fixed widths, constants and the divider interface types.
// Used by rsi_div, relative_strength_index and the testbench; depends on nothing.
package rsi_pkg;

    localparam int AVG_BITS    = 56;
    localparam int DIV_W       = AVG_BITS + 1;
    localparam int STEP_W      = $clog2(DIV_W + 1);
    localparam int PERIOD_BITS = 8;
    localparam int RSI_BITS    = 23;
    localparam int RATIO_SHIFT = 18;
    localparam int G25_W       = AVG_BITS + 5;

    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 8'd14;
    localparam logic [PERIOD_BITS-1:0] COUNT_MAX    = 8'd255;
    localparam logic [RSI_BITS-1:0]    RSI_FULL     = 23'd6553600;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [DIV_W-1:0]  rem;
        logic [DIV_W-1:0]  num;
        logic [DIV_W-1:0]  den;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quot;
    } t_div_rsp;

endpackage

// ===== src/rsi_div.sv =====
// Shared restoring divider of the RSI block, one quotient bit per cycle.
// Depends on rsi_pkg for widths and the request and response types.
module rsi_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rsi_pkg::t_div_req  i_req,
    output rsi_pkg::t_div_rsp  o_rsp
);
    import rsi_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_num;
    logic [DIV_W-1:0]  r_den;
    logic [DIV_W-1:0]  r_quot;
    logic [DIV_W:0]    shifted;
    logic [DIV_W+1:0]  diff;
    logic              fits;

    assign shifted = {r_rem, r_num[DIV_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_den};
    assign fits    = !diff[DIV_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.rem;
            r_num  <= i_req.num;
            r_den  <= i_req.den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
            r_num  <= {r_num[DIV_W-2:0], 1'b0};
            r_quot <= {r_quot[DIV_W-2:0], fits};
        end
    end

    assign o_rsp = '{busy: r_busy, done: r_done, quot: r_quot};

endmodule

// ===== src/relative_strength_index.sv =====
// Top level of the RSI block: sequencer, series state and output register.
// Depends on rsi_pkg, rsi_div and assert_macros.svh.
//
// Usage:
// The input channel carries one closing price and a series start flag per
// transfer (i_valid, o_stall). The output channel carries one RSI value in
// unsigned Q7.16 per transfer (o_valid, i_stall). The period register is
// written through i_cfg_we and i_cfg_wdata; the user must write it only
// while the block is idle, and the block itself does not enforce this.
// The first P prices of a series give no result. A warm-up price adds its
// gain and loss to the sums; on the price that ends warm-up both sums are
// divided by P on the shared divider (57 steps each). A later price runs two
// 57-step smoothing divisions and one 23-step ratio division, then loads the
// output register; with a zero average loss the ratio division is skipped.
// o_stall is high from the transfer until the sequencer is back in idle.
// A result waits in its own state while the output register still holds an
// unaccepted value, so a stalled receiver holds off the next input transfer.
// Reset clears the series state and the output valid and sets the period to 14.
`include "assert_macros.svh"

module relative_strength_index #(
    parameter int PRICE_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rsi_pkg::PERIOD_BITS-1:0] i_cfg_wdata,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [PRICE_BITS-1:0]           i_price,
    input  logic                            i_series_start,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [rsi_pkg::RSI_BITS-1:0]    o_rsi
);
    import rsi_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WARM,
        S_SETUP,
        S_DIV,
        S_RATIO,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        OP_WARM_GAIN,
        OP_WARM_LOSS,
        OP_SMOOTH_GAIN,
        OP_SMOOTH_LOSS,
        OP_RATIO
    } t_op;

    t_state                 r_state;
    t_op                    r_op;
    logic [PERIOD_BITS-1:0] r_period;
    logic [PRICE_BITS-1:0]  r_last;
    logic [PERIOD_BITS-1:0] r_count;
    logic [AVG_BITS-1:0]    r_gain;
    logic [AVG_BITS-1:0]    r_loss;
    logic [AVG_BITS-1:0]    r_xg;
    logic [AVG_BITS-1:0]    r_xl;
    logic                   r_hit;
    logic                   r_neg;
    logic [RSI_BITS-1:0]    r_res;
    logic                   r_o_valid;
    logic [RSI_BITS-1:0]    r_o_rsi;
    t_div_req               r_req;
    t_div_rsp               div_rsp;

    logic [PERIOD_BITS-1:0] p_eff;
    logic [PERIOD_BITS-1:0] base_count;
    logic [PERIOD_BITS-1:0] new_count;
    logic [PRICE_BITS-1:0]  base_last;
    logic [PRICE_BITS-1:0]  mag;
    logic                   up;
    logic [AVG_BITS-1:0]    dext;
    logic [AVG_BITS-1:0]    fixed;
    logic [AVG_BITS-1:0]    xg;
    logic [AVG_BITS-1:0]    xl;
    logic                   warm;
    logic                   hit;
    logic [AVG_BITS:0]      sum_g;
    logic [AVG_BITS:0]      sum_l;
    logic [AVG_BITS-1:0]    gain_sum;
    logic [AVG_BITS-1:0]    loss_sum;
    logic [AVG_BITS-1:0]    avg;
    logic [AVG_BITS-1:0]    x;
    logic                   neg;
    logic [DIV_W-1:0]       sdiv;
    logic [AVG_BITS-1:0]    q_avg;
    logic [AVG_BITS-1:0]    smooth_res;
    logic [G25_W-1:0]       g_ext;
    logic [G25_W-1:0]       g25;
    logic [DIV_W-1:0]       den;
    logic [RSI_BITS-1:0]    low_bits;

    always_comb begin
        p_eff      = (r_period == '0) ? PERIOD_BITS'(1) : r_period;
        base_count = i_series_start ? '0 : r_count;
        base_last  = i_series_start ? '0 : r_last;
        new_count  = (base_count == COUNT_MAX) ? COUNT_MAX : base_count + PERIOD_BITS'(1);
        up         = i_price > base_last;
        mag        = up ? i_price - base_last : base_last - i_price;
        dext       = AVG_BITS'(mag);
        fixed      = ((dext >> (AVG_BITS - FRAC_BITS)) != '0) ? '1 : (dext << FRAC_BITS);
        xg         = (base_count != '0 && up) ? fixed : '0;
        xl         = (base_count != '0 && !up) ? fixed : '0;
        warm       = base_count < p_eff;
        hit        = new_count == p_eff;

        sum_g    = {1'b0, r_gain} + {1'b0, r_xg};
        sum_l    = {1'b0, r_loss} + {1'b0, r_xl};
        gain_sum = sum_g[AVG_BITS] ? '1 : sum_g[AVG_BITS-1:0];
        loss_sum = sum_l[AVG_BITS] ? '1 : sum_l[AVG_BITS-1:0];

        avg  = (r_op == OP_SMOOTH_GAIN) ? r_gain : r_loss;
        x    = (r_op == OP_SMOOTH_GAIN) ? r_xg : r_xl;
        neg  = x < avg;
        sdiv = neg ? {1'b0, avg} - {1'b0, x} + DIV_W'(p_eff - PERIOD_BITS'(1))
                   : {1'b0, x} - {1'b0, avg};
        q_avg      = div_rsp.quot[AVG_BITS-1:0];
        smooth_res = r_neg ? avg - q_avg : avg + q_avg;

        g_ext    = G25_W'(r_gain);
        g25      = (g_ext << 4) + (g_ext << 3) + g_ext;
        den      = {1'b0, r_gain} + {1'b0, r_loss};
        low_bits = {g25[RSI_BITS-RATIO_SHIFT-1:0], {RATIO_SHIFT{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_op      <= OP_SMOOTH_GAIN;
            r_period  <= PERIOD_RESET;
            r_last    <= '0;
            r_count   <= '0;
            r_gain    <= '0;
            r_loss    <= '0;
            r_o_valid <= 1'b0;
            r_req     <= '0;
        end else begin
            r_req.start <= 1'b0;
            if (i_cfg_we) begin
                r_period <= i_cfg_wdata;
            end
            if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_last  <= i_price;
                        r_count <= new_count;
                        r_xg    <= xg;
                        r_xl    <= xl;
                        r_hit   <= hit;
                        r_op    <= OP_SMOOTH_GAIN;
                        if (i_series_start) begin
                            r_gain <= '0;
                            r_loss <= '0;
                        end
                        r_state <= warm ? S_WARM : S_SETUP;
                    end
                end
                S_WARM: begin
                    r_gain <= gain_sum;
                    r_loss <= loss_sum;
                    if (r_hit) begin
                        r_req <= '{start: 1'b1, steps: STEP_W'(DIV_W), rem: '0,
                                   num: DIV_W'(gain_sum), den: DIV_W'(p_eff)};
                        r_op    <= OP_WARM_GAIN;
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_SETUP: begin
                    r_neg   <= neg;
                    r_req   <= '{start: 1'b1, steps: STEP_W'(DIV_W), rem: '0,
                                 num: sdiv, den: DIV_W'(p_eff)};
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        unique case (r_op)
                            OP_WARM_GAIN: begin
                                r_gain <= q_avg;
                                r_req  <= '{start: 1'b1, steps: STEP_W'(DIV_W), rem: '0,
                                            num: DIV_W'(r_loss), den: DIV_W'(p_eff)};
                                r_op   <= OP_WARM_LOSS;
                            end
                            OP_WARM_LOSS: begin
                                r_loss  <= q_avg;
                                r_state <= S_IDLE;
                            end
                            OP_SMOOTH_GAIN: begin
                                r_gain  <= smooth_res;
                                r_op    <= OP_SMOOTH_LOSS;
                                r_state <= S_SETUP;
                            end
                            OP_SMOOTH_LOSS: begin
                                r_loss  <= smooth_res;
                                r_state <= S_RATIO;
                            end
                            OP_RATIO: begin
                                r_res   <= div_rsp.quot[RSI_BITS-1:0];
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_RATIO: begin
                    if (r_loss == '0) begin
                        r_res   <= RSI_FULL;
                        r_state <= S_OUT;
                    end else begin
                        r_req <= '{start: 1'b1, steps: STEP_W'(RSI_BITS),
                                   rem: DIV_W'(g25 >> (RSI_BITS - RATIO_SHIFT)),
                                   num: {low_bits, {(DIV_W - RSI_BITS){1'b0}}},
                                   den: den};
                        r_op    <= OP_RATIO;
                        r_state <= S_DIV;
                    end
                end
                S_OUT: begin
                    if (!r_o_valid || !i_stall) begin
                        r_o_valid <= 1'b1;
                        r_o_rsi   <= r_res;
                        r_state   <= S_IDLE;
                    end
                end
            endcase
        end
    end

    rsi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .o_rsp   (div_rsp)
    );

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_o_valid;
    assign o_rsi   = r_o_rsi;

    `ASSERT_IMP(a_rsi_range, o_valid, o_rsi <= RSI_FULL, "RSI result above full scale")
    `ASSERT_NXT(a_div_entry, r_req.start, r_state == S_DIV && div_rsp.busy, "divider not started")
    `ASSERT_IMP(a_done_in_div, div_rsp.done, r_state == S_DIV, "divider done outside divide state")
    `ASSERT_IMP(a_idle_free, r_state == S_IDLE, !div_rsp.busy, "divider busy while idle")

endmodule

// ===== sim/tb.sv =====
// Testbench for relative_strength_index: random and directed price streams with a
// scoreboard that predicts each RSI result. Depends on rsi_pkg and the RTL top level.
module tb;

    localparam int PRICE_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int RANDOM_ITEMS = 1800;
    localparam int SETTLE_CYCLES = 200;
    localparam int unsigned CYCLE_LIMIT = 3000000;
    localparam logic [63:0] AVG_MAX = (64'd1 << rsi_pkg::AVG_BITS) - 64'd1;

    typedef logic [rsi_pkg::RSI_BITS-1:0] t_rsi;

    class rsi_scoreboard;
        logic [rsi_pkg::PERIOD_BITS-1:0] period;
        logic [PRICE_BITS-1:0] last_price;
        logic [7:0] samples_seen;
        logic [63:0] gain_avg;
        logic [63:0] loss_avg;
        t_rsi expected_rsi[$];
        int unsigned errors;

        function new();
            period = rsi_pkg::PERIOD_RESET;
            errors = 0;
            clear_series();
        endfunction

        function void clear_series();
            last_price = '0;
            samples_seen = '0;
            gain_avg = '0;
            loss_avg = '0;
        endfunction

        function void set_period(logic [rsi_pkg::PERIOD_BITS-1:0] value);
            period = value;
        endfunction

        function int pending();
            return expected_rsi.size();
        endfunction

        function void add_expected(t_rsi value);
            expected_rsi = {expected_rsi, value};
        endfunction

        function logic [63:0] to_fixed(logic [63:0] diff);
            if (diff > (AVG_MAX >> FRAC_BITS)) begin
                return AVG_MAX;
            end
            return diff << FRAC_BITS;
        endfunction

        function logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
            logic [63:0] sum;
            sum = a + b;
            return (sum > AVG_MAX) ? AVG_MAX : sum;
        endfunction

        // Wilder smoothing (avg*(p-1) + x) / p, truncated.
        function logic [63:0] smooth(logic [63:0] avg, logic [63:0] x, logic [63:0] p);
            if (x >= avg) begin
                return avg + (x - avg) / p;
            end
            return avg - ((avg - x) + p - 64'd1) / p;
        endfunction

        function t_rsi ratio(logic [63:0] g, logic [63:0] d);
            logic [127:0] num;
            logic [127:0] quot;
            num = {64'd0, g} * 128'(rsi_pkg::RSI_FULL);
            quot = num / {64'd0, d};
            return quot[rsi_pkg::RSI_BITS-1:0];
        endfunction

        function void note_price(logic [PRICE_BITS-1:0] price, logic start);
            logic [63:0] p;
            logic [63:0] gain;
            logic [63:0] loss;
            logic [7:0] old_count;
            p = (period == '0) ? 64'd1 : {56'd0, period};
            if (start) begin
                clear_series();
            end
            old_count = samples_seen;
            gain = '0;
            loss = '0;
            if (old_count != 0) begin
                if (price > last_price) begin
                    gain = to_fixed(64'(price - last_price));
                end else begin
                    loss = to_fixed(64'(last_price - price));
                end
            end
            last_price = price;
            if (samples_seen != rsi_pkg::COUNT_MAX) begin
                samples_seen++;
            end
            if ({56'd0, old_count} < p) begin
                if (old_count != 0) begin
                    gain_avg = sat_add(gain_avg, gain);
                    loss_avg = sat_add(loss_avg, loss);
                end
                if ({56'd0, samples_seen} == p) begin
                    gain_avg = gain_avg / p;
                    loss_avg = loss_avg / p;
                end
                return;
            end
            gain_avg = smooth(gain_avg, gain, p);
            loss_avg = smooth(loss_avg, loss, p);
            if (loss_avg == 0) begin
                add_expected(rsi_pkg::RSI_FULL);
            end else begin
                add_expected(ratio(gain_avg, gain_avg + loss_avg));
            end
        endfunction

        function void check_rsi(t_rsi rsi);
            t_rsi exp_rsi;
            if (expected_rsi.size() == 0) begin
                $error("rsi: unexpected result, actual %0d", rsi);
                errors++;
                return;
            end
            exp_rsi = expected_rsi.pop_front();
            if (exp_rsi !== rsi) begin
                $error("rsi: expected %0d, actual %0d", exp_rsi, rsi);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [rsi_pkg::PERIOD_BITS-1:0] i_cfg_wdata;
    logic i_valid;
    logic o_stall;
    logic [PRICE_BITS-1:0] i_price;
    logic i_series_start;
    logic o_valid;
    logic i_stall;
    t_rsi o_rsi;

    rsi_scoreboard sb = new();
    bit no_idle;
    int unsigned rx_hold;
    int unsigned cycle_count;
    logic [PRICE_BITS-1:0] walk_price;

    relative_strength_index #(
        .PRICE_BITS(PRICE_BITS),
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_price(i_price),
        .i_series_start(i_series_start),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_rsi(o_rsi)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            sb.note_price(i_price, i_series_start);
        end
    end

    // The receiver draws its stall length per result and counts it down
    // only while a result is offered.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                sb.check_rsi(o_rsi);
                rx_hold = no_idle ? 0 : $urandom_range(0, 6);
                i_stall <= (rx_hold != 0);
            end else if (o_valid && rx_hold != 0) begin
                rx_hold--;
                i_stall <= (rx_hold != 0);
            end
        end
    end

    task automatic send_price(input logic [PRICE_BITS-1:0] price, input logic start);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_price <= price;
        i_series_start <= start;
        do begin
            @(posedge i_clk);
        end while (o_stall);
    endtask

    task automatic write_period(input logic [rsi_pkg::PERIOD_BITS-1:0] value);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        sb.set_period(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [PRICE_BITS-1:0] next_price(int unsigned mode);
        int unsigned step;
        step = $urandom_range(0, 1000);
        case (mode)
            0: begin
                walk_price = $urandom;
            end
            1: begin
                walk_price = $urandom_range(0, 1) ? walk_price + step : walk_price - step;
            end
            2: begin
                walk_price = walk_price + $urandom_range(0, 50);
            end
            default: begin
                if ($urandom_range(0, 7) == 0) begin
                    walk_price = $urandom;
                end
            end
        endcase
        return walk_price;
    endfunction

    initial begin
        int unsigned items_sent;
        int unsigned phase_count;
        int unsigned eff_period;
        int unsigned phase_len;
        int unsigned mode;
        int unsigned pick;
        bit fresh;
        logic [rsi_pkg::PERIOD_BITS-1:0] per;

        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_valid = 1'b0;
        i_price = '0;
        i_series_start = 1'b0;
        no_idle = 1'b0;
        cycle_count = 0;
        walk_price = $urandom;
        rx_hold = $urandom_range(0, 6);
        i_stall = (rx_hold != 0);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The first price after reset opens a series without the start flag.
        write_period(8'd3);
        send_price(32'd0, 1'b0);
        send_price(32'hFFFF_FFFF, 1'b0);
        send_price(32'd0, 1'b0);
        send_price(32'd5, 1'b0);
        // Only gains, then flat prices, then only losses.
        send_price(32'd100, 1'b1);
        send_price(32'd101, 1'b0);
        send_price(32'd102, 1'b0);
        send_price(32'd104, 1'b0);
        send_price(32'd7, 1'b1);
        send_price(32'd7, 1'b0);
        send_price(32'd7, 1'b0);
        send_price(32'd7, 1'b0);
        send_price(32'd50, 1'b1);
        send_price(32'd40, 1'b0);
        send_price(32'd30, 1'b0);
        send_price(32'd20, 1'b0);
        // A period of zero behaves as a period of one.
        write_period(8'd0);
        send_price(32'd1000, 1'b1);
        send_price(32'd0, 1'b0);
        send_price(32'hFFFF_FFFF, 1'b0);
        // The period grows in the middle of a series.
        write_period(8'd2);
        send_price(32'd10, 1'b1);
        send_price(32'd20, 1'b0);
        send_price(32'd15, 1'b0);
        write_period(8'd5);
        send_price(32'd30, 1'b0);
        send_price(32'd25, 1'b0);
        send_price(32'd40, 1'b0);

        items_sent = 0;
        phase_count = 0;
        while (items_sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (phase_count == 0 || pick < 4) begin
                per = rsi_pkg::COUNT_MAX;
            end else if (pick < 12) begin
                per = 8'd1;
            end else if (pick < 15) begin
                per = 8'd0;
            end else begin
                per = 8'($urandom_range(2, 20));
            end
            write_period(per);
            eff_period = (per == 0) ? 1 : per;
            phase_len = (eff_period > 200) ? eff_period + 40
                                           : $urandom_range(eff_period + 10, eff_period + 60);
            fresh = ($urandom_range(0, 9) < 7);
            mode = $urandom_range(0, 3);
            no_idle = ($urandom_range(0, 4) == 0);
            for (int i = 0; i < phase_len && items_sent < RANDOM_ITEMS; i++) begin
                send_price(next_price(mode), (i == 0 && fresh) || $urandom_range(0, 49) == 0);
                items_sent++;
            end
            phase_count++;
        end

        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== relative_strength_index.f =====
+incdir+src
src/rsi_pkg.sv
src/rsi_div.sv
src/relative_strength_index.sv
sim/tb.sv
